@@ hdl/lcb_pkg.sv @@
// ----------------------------------------------------------------------------
// lcb_pkg
// Shared constants and types for the log crystal ball function core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcb_pkg;

    localparam int OUT_W    = 48;
    localparam int IN_W     = 32;
    localparam int LOG_FRAC = 30;
    localparam int MANT_W   = LOG_FRAC + 1;
    localparam int SENTINEL_INT = 9999999;

    localparam logic [LOG_FRAC-1:0] LN2_Q30 = 30'd744261118;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [63:0]      MAG_LIM = 64'd1 << (OUT_W - 1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SENTINEL = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

endpackage

`default_nettype wire

@@ hdl/lcb_div.sv @@
// ----------------------------------------------------------------------------
// lcb_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcb_div #(
    parameter int QW = 49,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [QW-1:0] i_num_a,
    input  wire logic [DW-1:0] i_den_a,
    input  wire logic [QW-1:0] i_num_b,
    input  wire logic [DW-1:0] i_den_b,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo_a,
    output logic [QW-1:0]      o_quo_b,
    output logic [SW-1:0]      o_side
);

    localparam int AW = DW + QW;

    function automatic logic [AW-1:0] f_step(input logic [AW-1:0] acc,
                                             input logic [DW-1:0] den);
        logic [DW:0]   top;
        logic [DW:0]   diff;
        logic [AW-1:0] res;
        top  = acc[AW-1:QW-1];
        diff = top - {1'b0, den};
        if (top >= {1'b0, den}) begin
            res = {diff[DW-1:0], acc[QW-2:0], 1'b1};
        end else begin
            res = {top[DW-1:0], acc[QW-2:0], 1'b0};
        end
        return res;
    endfunction

    logic          r_vld   [0:QW-1];
    logic [AW-1:0] r_acc_a [0:QW-1];
    logic [AW-1:0] r_acc_b [0:QW-1];
    logic [DW-1:0] r_den_a [0:QW-2];
    logic [DW-1:0] r_den_b [0:QW-2];
    logic [SW-1:0] r_side  [0:QW-1];

    genvar g;
    generate
        for (g = 0; g < QW; g++) begin : g_stage
            if (g == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_vld[g] <= 1'b0;
                    end else begin
                        r_vld[g] <= i_valid;
                    end
                end
                always_ff @(posedge i_clk) begin
                    r_acc_a[g] <= f_step({{DW{1'b0}}, i_num_a}, i_den_a);
                    r_acc_b[g] <= f_step({{DW{1'b0}}, i_num_b}, i_den_b);
                    r_den_a[g] <= i_den_a;
                    r_den_b[g] <= i_den_b;
                    r_side[g]  <= i_side;
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_vld[g] <= 1'b0;
                    end else begin
                        r_vld[g] <= r_vld[g-1];
                    end
                end
                always_ff @(posedge i_clk) begin
                    r_acc_a[g] <= f_step(r_acc_a[g-1], r_den_a[g-1]);
                    r_acc_b[g] <= f_step(r_acc_b[g-1], r_den_b[g-1]);
                    r_side[g]  <= r_side[g-1];
                end
                if (g < QW - 1) begin : g_den
                    always_ff @(posedge i_clk) begin
                        r_den_a[g] <= r_den_a[g-1];
                        r_den_b[g] <= r_den_b[g-1];
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[QW-1];
    assign o_quo_a = r_acc_a[QW-1][QW-1:0];
    assign o_quo_b = r_acc_b[QW-1][QW-1:0];
    assign o_side  = r_side[QW-1];

endmodule

`default_nettype wire

@@ hdl/lcb_log2.sv @@
// ----------------------------------------------------------------------------
// lcb_log2
// Two-lane pipelined base-2 logarithm, integer part plus 30 fraction bits
// from one mantissa squaring per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcb_log2 #(
    parameter int IN_W = 52,
    parameter int SW   = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [IN_W-1:0] i_val_a,
    input  wire logic [IN_W-1:0] i_val_b,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_valid,
    output logic [$clog2(IN_W)+lcb_pkg::LOG_FRAC-1:0] o_log_a,
    output logic [$clog2(IN_W)+lcb_pkg::LOG_FRAC-1:0] o_log_b,
    output logic [SW-1:0]        o_side
);

    localparam int KW   = $clog2(IN_W);
    localparam int ITER = lcb_pkg::LOG_FRAC;
    localparam int MW   = lcb_pkg::MANT_W;
    localparam int NP   = ITER + 2;

    function automatic logic [KW-1:0] f_msb(input logic [IN_W-1:0] v);
        logic [KW-1:0] k;
        k = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (v[i]) begin
                k = KW'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [MW-1:0] f_norm(input logic [IN_W-1:0] v,
                                             input logic [KW-1:0] k);
        logic [KW-1:0]   sh;
        logic [IN_W-1:0] t;
        sh = KW'(IN_W - 1) - k;
        t  = v << sh;
        return t[IN_W-1 -: MW];
    endfunction

    function automatic logic [MW:0] f_square(input logic [MW-1:0] m);
        logic [2*MW-1:0]      p;
        logic [2*MW-ITER-1:0] s;
        logic [MW:0]          res;
        p = m * m;
        s = p[2*MW-1:ITER];
        if (s[MW]) begin
            res = {s[MW:1], 1'b1};
        end else begin
            res = {s[MW-1:0], 1'b0};
        end
        return res;
    endfunction

    logic            r_vld  [0:NP-1];
    logic [SW-1:0]   r_side [0:NP-1];
    logic [IN_W-1:0] r_v_a;
    logic [IN_W-1:0] r_v_b;
    logic [KW-1:0]   r_k_a  [0:NP-1];
    logic [KW-1:0]   r_k_b  [0:NP-1];
    logic [MW-1:0]   r_m_a  [1:NP-1];
    logic [MW-1:0]   r_m_b  [1:NP-1];
    logic [ITER-1:0] r_f_a  [2:NP-1];
    logic [ITER-1:0] r_f_b  [2:NP-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v_a     <= i_val_a;
        r_v_b     <= i_val_b;
        r_k_a[0]  <= f_msb(i_val_a);
        r_k_b[0]  <= f_msb(i_val_b);
        r_side[0] <= i_side;
    end

    genvar g;
    generate
        for (g = 1; g < NP; g++) begin : g_stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else begin
                    r_vld[g] <= r_vld[g-1];
                end
            end
            always_ff @(posedge i_clk) begin
                r_k_a[g]  <= r_k_a[g-1];
                r_k_b[g]  <= r_k_b[g-1];
                r_side[g] <= r_side[g-1];
            end
            if (g == 1) begin : g_norm
                always_ff @(posedge i_clk) begin
                    r_m_a[g] <= f_norm(r_v_a, r_k_a[0]);
                    r_m_b[g] <= f_norm(r_v_b, r_k_b[0]);
                end
            end else begin : g_sq
                logic [MW:0] w_sa;
                logic [MW:0] w_sb;
                logic [ITER-1:0] w_fa;
                logic [ITER-1:0] w_fb;
                assign w_sa = f_square(r_m_a[g-1]);
                assign w_sb = f_square(r_m_b[g-1]);
                if (g == 2) begin : g_f0
                    assign w_fa = '0;
                    assign w_fb = '0;
                end else begin : g_fn
                    assign w_fa = r_f_a[g-1];
                    assign w_fb = r_f_b[g-1];
                end
                always_ff @(posedge i_clk) begin
                    r_m_a[g] <= w_sa[MW:1];
                    r_m_b[g] <= w_sb[MW:1];
                    r_f_a[g] <= {w_fa[ITER-2:0], w_sa[0]};
                    r_f_b[g] <= {w_fb[ITER-2:0], w_sb[0]};
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[NP-1];
    assign o_log_a = {r_k_a[NP-1], r_f_a[NP-1]};
    assign o_log_b = {r_k_b[NP-1], r_f_b[NP-1]};
    assign o_side  = r_side[NP-1];

endmodule

`default_nettype wire

@@ hdl/log_crystal_ball_function_core.sv @@
// ----------------------------------------------------------------------------
// log_crystal_ball_function_core
// Log of the unnormalized crystal ball function: gaussian core or power-law
// tail, with sentinel and saturation status.
// the pipeline runs through the one-bit-per-stage dividers and the
// 30 squaring stages of the logarithm
// throughput: one item per cycle, busy stays low, results cannot be held off
// reset clears the valid bits only; items in flight are dropped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module log_crystal_ball_function_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_point,
    input  wire logic [31:0] i_tail_alpha,
    input  wire logic [31:0] i_tail_power,
    input  wire logic [31:0] i_width_sigma,
    input  wire logic [31:0] i_center_mean,
    output logic             o_valid,
    output logic [47:0]      o_log_value,
    output logic             o_in_tail,
    output logic [1:0]       o_status
);

    localparam int OW  = lcb_pkg::OUT_W;
    localparam int IW  = lcb_pkg::IN_W;
    localparam int QW  = IW + 1 + FRAC_BITS;
    localparam int ZW  = QW + 1;
    localparam int DNW = QW + 3;
    localparam int ZMW = (FRAC_BITS + 50) / 2;
    localparam int PW  = 2 * ZMW - FRAC_BITS - 1;
    localparam int HW  = 2 * IW - FRAC_BITS - 1;
    localparam int LF  = lcb_pkg::LOG_FRAC;
    localparam int LW  = $clog2(DNW) + LF;
    localparam int TW  = LW + 2;
    localparam int VW  = ((TW + 1 > HW) ? TW + 1 : HW) + 2;

    localparam longint SENT_FULL = -(longint'(lcb_pkg::SENTINEL_INT) <<< FRAC_BITS);
    localparam longint SAT_LIM   = longint'(1) <<< (OW - 1);
    localparam logic [OW-1:0] SENT_VAL =
        (SENT_FULL < -SAT_LIM) ? lcb_pkg::OUT_MIN : SENT_FULL[OW-1:0];

    typedef struct packed {
        logic          zneg;
        logic          sig_neg;
        logic          sig_zero;
        logic          a_zero;
        logic          n_neg;
        logic          n_zero;
        logic [IW-1:0] amag;
        logic [IW-1:0] nmag;
    } t_pre;

    typedef struct packed {
        logic [OW-1:0]    value;
        lcb_pkg::t_status status;
        logic             tail;
        logic             use_term;
        logic             n_neg;
        logic [IW-1:0]    nmag;
        logic [HW-1:0]    half;
    } t_mid;

    assign busy = 1'b0;

    // input stage
    logic [IW:0]   w_d;
    logic [IW:0]   w_dmag;
    logic [IW-1:0] w_amag;
    logic [IW-1:0] w_nmag;

    assign w_d    = {i_point[IW-1], i_point} - {i_center_mean[IW-1], i_center_mean};
    assign w_dmag = w_d[IW] ? ((IW+1)'(0) - w_d) : w_d;
    assign w_amag = i_tail_alpha[IW-1] ? (IW'(0) - i_tail_alpha) : i_tail_alpha;
    assign w_nmag = i_tail_power[IW-1] ? (IW'(0) - i_tail_power) : i_tail_power;

    logic          r_s0_vld;
    logic [IW:0]   r_s0_dmag;
    logic [IW-1:0] r_s0_amag;
    logic [IW-1:0] r_s0_nmag;
    logic [IW-1:0] r_s0_sigma;
    logic          r_s0_zneg;
    logic          r_s0_nneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_dmag  <= w_dmag;
        r_s0_amag  <= w_amag;
        r_s0_nmag  <= w_nmag;
        r_s0_sigma <= i_width_sigma;
        r_s0_zneg  <= w_d[IW] ^ i_tail_alpha[IW-1];
        r_s0_nneg  <= i_tail_power[IW-1];
    end

    t_pre          w_pre;
    logic [IW-1:0] w_den_a;
    logic [IW-1:0] w_den_b;

    always_comb begin
        w_pre.zneg     = r_s0_zneg;
        w_pre.sig_neg  = r_s0_sigma[IW-1];
        w_pre.sig_zero = (r_s0_sigma == '0);
        w_pre.a_zero   = (r_s0_amag == '0);
        w_pre.n_neg    = r_s0_nneg;
        w_pre.n_zero   = (r_s0_nmag == '0);
        w_pre.amag     = r_s0_amag;
        w_pre.nmag     = r_s0_nmag;
    end

    assign w_den_a = (w_pre.sig_neg || w_pre.sig_zero) ? IW'(1) : r_s0_sigma;
    assign w_den_b = w_pre.a_zero ? IW'(1) : r_s0_amag;

    logic          w_dv_vld;
    logic [QW-1:0] w_q_a;
    logic [QW-1:0] w_q_b;
    t_pre          w_dv_side;

    lcb_div #(
        .QW (QW),
        .DW (IW),
        .SW ($bits(t_pre))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_vld),
        .i_num_a ({r_s0_dmag, {FRAC_BITS{1'b0}}}),
        .i_den_a (w_den_a),
        .i_num_b ({1'b0, r_s0_nmag, {FRAC_BITS{1'b0}}}),
        .i_den_b (w_den_b),
        .i_side  (w_pre),
        .o_valid (w_dv_vld),
        .o_quo_a (w_q_a),
        .o_quo_b (w_q_b),
        .o_side  (w_dv_side)
    );

    // signed z, quotient n/|alpha|, branch choice
    logic [ZW-1:0] w_zs;
    logic [ZW-1:0] w_nda;
    logic [ZW:0]   w_zsum;

    assign w_zs   = w_dv_side.zneg ? (ZW'(0) - {1'b0, w_q_a}) : {1'b0, w_q_a};
    assign w_nda  = w_dv_side.n_neg ? (ZW'(0) - {1'b0, w_q_b}) : {1'b0, w_q_b};
    assign w_zsum = {w_zs[ZW-1], w_zs} + (ZW+1)'(w_dv_side.amag);

    logic           r_e1_vld;
    logic [ZW-1:0]  r_e1_zs;
    logic [ZW-1:0]  r_e1_nda;
    logic [ZMW-1:0] r_e1_zm;
    logic           r_e1_zbig;
    logic           r_e1_tail;
    t_pre           r_e1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld <= 1'b0;
        end else begin
            r_e1_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1_zs   <= w_zs;
        r_e1_nda  <= w_nda;
        r_e1_zm   <= w_q_a[ZMW-1:0];
        r_e1_zbig <= |w_q_a[QW-1:ZMW];
        r_e1_tail <= w_zsum[ZW] || (w_zsum == '0);
        r_e1_side <= w_dv_side;
    end

    // squares and tail denominator
    logic [2*ZMW-1:0] w_zsq;
    logic [2*IW-1:0]  w_asq;
    logic [DNW-1:0]   w_den;

    assign w_zsq = r_e1_zm * r_e1_zm;
    assign w_asq = r_e1_side.amag * r_e1_side.amag;
    assign w_den = {{2{r_e1_nda[ZW-1]}}, r_e1_nda} - DNW'(r_e1_side.amag)
                 - {{2{r_e1_zs[ZW-1]}}, r_e1_zs};

    logic           r_e2_vld;
    logic [PW-1:0]  r_e2_core;
    logic [HW-1:0]  r_e2_half;
    logic [DNW-1:0] r_e2_den;
    logic [ZW-1:0]  r_e2_nda;
    logic           r_e2_zbig;
    logic           r_e2_tail;
    t_pre           r_e2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_vld <= 1'b0;
        end else begin
            r_e2_vld <= r_e1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e2_core <= w_zsq[2*ZMW-1:FRAC_BITS+1];
        r_e2_half <= w_asq[2*IW-1:FRAC_BITS+1];
        r_e2_den  <= w_den;
        r_e2_nda  <= r_e1_nda;
        r_e2_zbig <= r_e1_zbig;
        r_e2_tail <= r_e1_tail;
        r_e2_side <= r_e1_side;
    end

    // early result and log operands
    logic [63:0]    w_core64;
    logic [63:0]    w_half64;
    logic           w_core_sat;
    logic           w_half_sat;
    logic [OW-1:0]  w_core_val;
    logic [OW-1:0]  w_half_val;
    logic [ZW-1:0]  w_ndamag;
    logic [DNW-1:0] w_denmag;
    t_mid           w_mid;

    assign w_core64   = 64'(r_e2_core);
    assign w_half64   = 64'(r_e2_half);
    assign w_core_sat = r_e2_zbig || (w_core64 > lcb_pkg::MAG_LIM);
    assign w_half_sat = w_half64 > lcb_pkg::MAG_LIM;
    assign w_core_val = w_core_sat ? lcb_pkg::OUT_MIN : (OW'(0) - w_core64[OW-1:0]);
    assign w_half_val = w_half_sat ? lcb_pkg::OUT_MIN : (OW'(0) - w_half64[OW-1:0]);
    assign w_ndamag   = r_e2_nda[ZW-1] ? (ZW'(0) - r_e2_nda) : r_e2_nda;
    assign w_denmag   = r_e2_den[DNW-1] ? (DNW'(0) - r_e2_den) : r_e2_den;

    always_comb begin
        w_mid.value    = lcb_pkg::OUT_MIN;
        w_mid.status   = lcb_pkg::ST_SAT;
        w_mid.tail     = 1'b1;
        w_mid.use_term = 1'b0;
        w_mid.n_neg    = r_e2_side.n_neg;
        w_mid.nmag     = r_e2_side.nmag;
        w_mid.half     = r_e2_half;
        if (r_e2_side.sig_neg) begin
            w_mid.value  = SENT_VAL;
            w_mid.status = lcb_pkg::ST_SENTINEL;
            w_mid.tail   = 1'b0;
        end else if (r_e2_side.sig_zero) begin
            w_mid.tail   = 1'b0;
        end else if (!r_e2_tail) begin
            w_mid.value  = w_core_val;
            w_mid.status = w_core_sat ? lcb_pkg::ST_SAT : lcb_pkg::ST_OK;
            w_mid.tail   = 1'b0;
        end else if (r_e2_side.a_zero) begin
            w_mid.value  = lcb_pkg::OUT_MIN;
        end else if (r_e2_side.n_zero) begin
            w_mid.value  = w_half_val;
            w_mid.status = w_half_sat ? lcb_pkg::ST_SAT : lcb_pkg::ST_OK;
        end else if (r_e2_nda == '0) begin
            w_mid.value  = r_e2_side.n_neg ? lcb_pkg::OUT_MAX : lcb_pkg::OUT_MIN;
        end else if (r_e2_side.n_neg && !r_e2_den[DNW-1]) begin
            w_mid.value  = lcb_pkg::OUT_MIN;
        end else begin
            w_mid.use_term = 1'b1;
            w_mid.status   = lcb_pkg::ST_OK;
        end
    end

    logic           r_e3_vld;
    logic [DNW-1:0] r_e3_la_in;
    logic [DNW-1:0] r_e3_lb_in;
    t_mid           r_e3_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e3_vld <= 1'b0;
        end else begin
            r_e3_vld <= r_e2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e3_la_in <= DNW'(w_ndamag);
        r_e3_lb_in <= w_denmag;
        r_e3_mid   <= w_mid;
    end

    logic          w_lg_vld;
    logic [LW-1:0] w_lg_a;
    logic [LW-1:0] w_lg_b;
    t_mid          w_lg_mid;

    lcb_log2 #(
        .IN_W (DNW),
        .SW   ($bits(t_mid))
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e3_vld),
        .i_val_a (r_e3_la_in),
        .i_val_b (r_e3_lb_in),
        .i_side  (r_e3_mid),
        .o_valid (w_lg_vld),
        .o_log_a (w_lg_a),
        .o_log_b (w_lg_b),
        .o_side  (w_lg_mid)
    );

    // log difference
    logic [LW:0] w_dl;
    logic [LW:0] w_dlmag;

    assign w_dl    = {1'b0, w_lg_a} - {1'b0, w_lg_b};
    assign w_dlmag = w_dl[LW] ? ((LW+1)'(0) - w_dl) : w_dl;

    logic          r_p1_vld;
    logic          r_p1_dneg;
    logic [LW-1:0] r_p1_dmag;
    t_mid          r_p1_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= w_lg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_dneg <= w_dl[LW];
        r_p1_dmag <= w_dlmag[LW-1:0];
        r_p1_mid  <= w_lg_mid;
    end

    // times ln2
    logic [LW+LF-1:0] w_lnp;

    assign w_lnp = r_p1_dmag * lcb_pkg::LN2_Q30;

    logic          r_p2_vld;
    logic          r_p2_neg;
    logic [LW-1:0] r_p2_lnm;
    t_mid          r_p2_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_neg <= r_p1_dneg ^ r_p1_mid.n_neg;
        r_p2_lnm <= w_lnp[LW+LF-1:LF];
        r_p2_mid <= r_p1_mid;
    end

    // times n
    logic [IW+LW-1:0] w_tp;

    assign w_tp = r_p2_mid.nmag * r_p2_lnm;

    logic          r_p3_vld;
    logic          r_p3_neg;
    logic [TW-1:0] r_p3_tm;
    t_mid          r_p3_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else begin
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p3_neg <= r_p2_neg;
        r_p3_tm  <= w_tp[IW+LW-1:LF];
        r_p3_mid <= r_p2_mid;
    end

    // tail sum, clamp and output register
    logic [VW-1:0] w_term;
    logic [VW-1:0] w_v;
    logic          w_hi;
    logic          w_lo;
    logic [OW-1:0] w_tail_val;

    assign w_term = r_p3_neg ? (VW'(0) - VW'(r_p3_tm)) : VW'(r_p3_tm);
    assign w_v    = w_term - VW'(r_p3_mid.half);
    assign w_hi   = $signed(w_v) > $signed({{(VW-OW){1'b0}}, lcb_pkg::OUT_MAX});
    assign w_lo   = $signed(w_v) < $signed({{(VW-OW){1'b1}}, lcb_pkg::OUT_MIN});
    assign w_tail_val = w_hi ? lcb_pkg::OUT_MAX :
                        w_lo ? lcb_pkg::OUT_MIN : w_v[OW-1:0];

    logic             r_out_vld;
    logic [OW-1:0]    r_out_value;
    logic             r_out_tail;
    lcb_pkg::t_status r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_p3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_tail <= r_p3_mid.tail;
        if (r_p3_mid.use_term) begin
            r_out_value  <= w_tail_val;
            r_out_status <= (w_hi || w_lo) ? lcb_pkg::ST_SAT : lcb_pkg::ST_OK;
        end else begin
            r_out_value  <= r_p3_mid.value;
            r_out_status <= r_p3_mid.status;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_log_value = r_out_value;
    assign o_in_tail   = r_out_tail;
    assign o_status    = r_out_status;

`ifndef SYNTH
    a_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == lcb_pkg::ST_SENTINEL) |->
        (o_log_value == SENT_VAL && !o_in_tail))
        else $error("sentinel item has wrong value or tail flag");

    a_core_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_tail && o_status == lcb_pkg::ST_OK) |->
        (o_log_value[OW-1] || o_log_value == '0))
        else $error("gaussian core item is positive");

    a_core_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_tail && o_status == lcb_pkg::ST_SAT) |->
        (o_log_value == lcb_pkg::OUT_MIN))
        else $error("saturated core item is not the lower bound");

    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e3_vld && !r_e3_mid.use_term) |->
        !(r_e3_mid.status == lcb_pkg::ST_SENTINEL && r_e3_mid.tail))
        else $error("sentinel item marked as tail");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_log_crystal_ball_function_core.sv @@
// ----------------------------------------------------------------------------
// tb_log_crystal_ball_function_core
// Self-checking bench for the log crystal ball function core: a directed
// table of corner items, then random items biased toward the power-law tail,
// under several sender idle patterns, each result checked against the model or a stored value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_log_crystal_ball_function_core;

    localparam int FRAC    = 16;
    localparam int N_RAND  = 1850;
    localparam int WD_MAX  = 2000;
    localparam int DRAIN   = 200;
    localparam logic [47:0] SENT_VAL = 48'hFF67_6981_0000;

    typedef struct packed {
        logic [47:0]      value;
        logic             tail;
        lcb_pkg::t_status status;
    } cb_res_t;

    typedef struct packed {
        logic [31:0] x, alpha, n, sigma, mean;
        logic        fixed;
        cb_res_t     res;
    } cb_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] i_point = '0, i_tail_alpha = '0, i_tail_power = '0;
    logic [31:0] i_width_sigma = '0, i_center_mean = '0;
    logic        drv_fixed = 1'b0;
    cb_res_t     drv_res = '0;
    wire         busy, o_valid, o_in_tail;
    wire  [47:0] o_log_value;
    wire  [1:0]  o_status;

    cb_res_t expected_q[$];
    int      errors = 0;
    int      idle_cycles = 0;

    log_crystal_ball_function_core #(.FRAC_BITS(FRAC)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_point(i_point), .i_tail_alpha(i_tail_alpha), .i_tail_power(i_tail_power),
        .i_width_sigma(i_width_sigma), .i_center_mean(i_center_mean),
        .o_valid(o_valid), .o_log_value(o_log_value), .o_in_tail(o_in_tail),
        .o_status(o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint trunc_mul(longint a, longint b, int s, inout bit sat);
        logic [127:0] p;
        logic [63:0]  m;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        p = p >> s;
        if (p > 128'(64'd1 << 62)) begin
            m = 64'd1 << 62;
            sat = 1'b1;
        end else begin
            m = p[63:0];
        end
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint log2_fix(logic [63:0] v);
        int          k;
        logic [63:0] m;
        longint      frac;
        k = 63;
        frac = 0;
        while (k > 0 && !v[k]) k--;
        m = (k >= 30) ? (v >> (k - 30)) : (v << (30 - k));
        for (int i = 1; i <= 30; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | (longint'(1) << (30 - i));
            end
        end
        return (longint'(k) << 30) + frac;
    endfunction

    function automatic cb_res_t predict_log_cb(logic [31:0] xi, ai, ni, si, mi);
        longint x, alpha, n, sigma, mean, value, z, a, d, half_a2, nda, den, dl, lnv;
        logic [63:0] q;
        bit      sat;
        cb_res_t r;
        x = longint'($signed(xi));
        alpha = longint'($signed(ai));
        n = longint'($signed(ni));
        sigma = longint'($signed(si));
        mean = longint'($signed(mi));
        sat = 1'b0;
        value = 0;
        r = '0;
        r.status = lcb_pkg::ST_OK;
        if (sigma < 0) begin
            value = -longint'(lcb_pkg::SENTINEL_INT) * (longint'(1) << FRAC);
            r.status = lcb_pkg::ST_SENTINEL;
        end else if (sigma == 0) begin
            value = -(longint'(1) << 47);
            r.status = lcb_pkg::ST_SAT;
        end else begin
            d = x - mean;
            q = (magnitude(d) << FRAC) / 64'(sigma);
            z = d < 0 ? -longint'(q) : longint'(q);
            if (alpha < 0) z = -z;
            a = longint'(magnitude(alpha));
            if (z > -a) begin
                value = -trunc_mul(z, z, FRAC + 1, sat);
            end else begin
                r.tail = 1'b1;
                if (a == 0) begin
                    value = -(longint'(1) << 47);
                    sat = 1'b1;
                end else begin
                    half_a2 = trunc_mul(a, a, FRAC + 1, sat);
                    q = (magnitude(n) << FRAC) / 64'(a);
                    nda = n < 0 ? -longint'(q) : longint'(q);
                    den = nda - a - z;
                    if (n == 0) begin
                        value = -half_a2;
                    end else if (nda == 0) begin
                        value = n > 0 ? -(longint'(1) << 47) : (longint'(1) << 47) - 1;
                        sat = 1'b1;
                    end else if (n < 0 && den >= 0) begin
                        value = -(longint'(1) << 47);
                        sat = 1'b1;
                    end else begin
                        dl = log2_fix(magnitude(nda)) - log2_fix(magnitude(den));
                        lnv = trunc_mul(dl, longint'(lcb_pkg::LN2_Q30), 30, sat);
                        value = trunc_mul(n, lnv, 30, sat) - half_a2;
                    end
                end
            end
            if (value > (longint'(1) << 47) - 1) begin
                value = (longint'(1) << 47) - 1;
                sat = 1'b1;
            end
            if (value < -(longint'(1) << 47)) begin
                value = -(longint'(1) << 47);
                sat = 1'b1;
            end
            if (sat) r.status = lcb_pkg::ST_SAT;
        end
        r.value = value[47:0];
        return r;
    endfunction

    // item acceptance and result checking
    always @(posedge i_clk) begin
        cb_res_t exp_r;
        if (i_rst_n && ((start && !busy) || o_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && start && !busy) begin
            if (drv_fixed)
                expected_q.push_back(drv_res);
            else
                expected_q.push_back(predict_log_cb(i_point, i_tail_alpha,
                    i_tail_power, i_width_sigma, i_center_mean));
        end
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result value=%h tail=%b status=%0d",
                         $time, o_log_value, o_in_tail, o_status);
                errors <= errors + 1;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_log_value !== exp_r.value || o_in_tail !== exp_r.tail
                        || o_status !== exp_r.status) begin
                    $display("%0t: expected %h/%b/%0d actual %h/%b/%0d",
                             $time, exp_r.value, exp_r.tail, exp_r.status,
                             o_log_value, o_in_tail, o_status);
                    errors <= errors + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WD_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    int idle_pct = 0;

    task automatic send_item(logic [31:0] x, alpha, n, sigma, mean,
                             logic fixed, cb_res_t res);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_point <= x;
        i_tail_alpha <= alpha;
        i_tail_power <= n;
        i_width_sigma <= sigma;
        i_center_mean <= mean;
        drv_fixed <= fixed;
        drv_res <= res;
        do begin
            @(negedge i_clk);
        end while (busy);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_q(int lo_int, int hi_int);
        return 32'($signed($urandom_range(hi_int - lo_int)) + lo_int) << FRAC
               | 32'($urandom_range(16'hFFFF));
    endfunction

    cb_row_t directed[] = '{
        '{32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0,
          1'b1, '{SENT_VAL, 1'b0, lcb_pkg::ST_SENTINEL}},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          1'b1, '{SENT_VAL, 1'b0, lcb_pkg::ST_SENTINEL}},
        '{32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0,
          1'b1, '{lcb_pkg::OUT_MIN, 1'b0, lcb_pkg::ST_SAT}},
        '{32'hFFFF_0000, 32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0,
          1'b1, '{lcb_pkg::OUT_MIN, 1'b1, lcb_pkg::ST_SAT}},
        '{32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000,
          1'b1, '{48'h0, 1'b0, lcb_pkg::ST_OK}},
        '{32'hFFFD_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 1'b0, '0},
        '{32'hFFFD_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF,
          1'b0, '0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
          1'b0, '0},
        '{32'hFFFC_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 1'b0, '0},
        '{32'hFFFC_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0100, 32'h0, 1'b0, '0},
        '{32'hFFFC_0000, 32'h0001_8000, 32'h0003_0000, 32'h0001_0000, 32'h0, 1'b0, '0},
        '{32'h0004_0000, 32'hFFFE_8000, 32'h0005_0000, 32'h0002_0000, 32'h0, 1'b0, '0},
        '{32'h7FFF_FFFF, 32'h0001_0000, 32'h0002_0000, 32'h0000_0001, 32'h8000_0000,
          1'b0, '0},
        '{32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
          1'b0, '0},
        '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b0, '0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000,
          1'b0, '0},
        '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
          1'b0, '0},
        '{32'h1234_5678, 32'h0002_0000, 32'h0004_0000, 32'h0001_0000, 32'h1230_0000,
          1'b0, '0}
    };

    initial begin
        logic [31:0] x, alpha, n, sigma, mean;
        int kind;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i])
            send_item(directed[i].x, directed[i].alpha, directed[i].n,
                      directed[i].sigma, directed[i].mean,
                      directed[i].fixed, directed[i].res);
        for (int i = 0; i < N_RAND; i++) begin
            case ((i * 4) / N_RAND)
                0: idle_pct = 0;
                1: idle_pct = 51;
                2: idle_pct = 0;
                default: idle_pct = 30;
            endcase
            if ((i % 50) < 5) idle_pct = 0;
            kind = $urandom_range(9);
            if (kind < 7) begin
                sigma = 32'($urandom_range(32'h0008_0000, 32'h0000_1000));
                alpha = rand_q(0, 4);
                if ($urandom_range(1)) alpha = -alpha;
                n = rand_q(-3, 20);
                mean = rand_q(-100, 100);
                x = mean + (($signed(alpha) < 0) ? rand_q(-2, 40) : -rand_q(-2, 40));
            end else if (kind < 9) begin
                sigma = $urandom();
                sigma[31] = 1'b0;
                if ($urandom_range(3) == 0) sigma = $urandom_range(255);
                alpha = $urandom();
                n = $urandom();
                x = $urandom();
                mean = $urandom();
            end else begin
                sigma = $urandom();
                alpha = $urandom();
                n = $urandom();
                x = $urandom();
                mean = $urandom();
            end
            send_item(x, alpha, n, sigma, mean, 1'b0, '0);
        end
        start <= 1'b0;
        drv_fixed <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
